// ===== design/s5a_pkg.sv =====
// ----------------------------------------------------------------------------
// s5a_pkg: shared types and constants of the SOCKS5 handshake engine
// Phase codes, sequencer states, cell operations and the cell control bundle.
// ----------------------------------------------------------------------------
package s5a_pkg;

  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned MaxTextDef    = 64;

  localparam logic [7:0] VerMethod = 8'h05;
  localparam logic [7:0] VerPasswd = 8'h01;
  localparam logic [7:0] MethNone  = 8'h00;
  localparam logic [7:0] MethPass  = 8'h02;
  localparam logic [7:0] MethRej   = 8'hFF;

  localparam logic [1:0] CmdClient = 2'd0;
  localparam logic [1:0] CmdText   = 2'd1;
  localparam logic [1:0] CmdLen    = 2'd2;
  localparam logic [1:0] CmdNewCon = 2'd3;

  localparam logic       RegAuthEn   = 1'b0;
  localparam logic       RegEntryCnt = 1'b1;

  localparam logic [2:0] MaskOff  = 3'd0;
  localparam logic [2:0] MaskNone = 3'd1;
  localparam logic [2:0] MaskPass = 3'd4;

  localparam logic [3:0] PhMVer    = 4'd0;
  localparam logic [3:0] PhMCount  = 4'd1;
  localparam logic [3:0] PhMList   = 4'd2;
  localparam logic [3:0] PhPVer    = 4'd3;
  localparam logic [3:0] PhPULen   = 4'd4;
  localparam logic [3:0] PhPName   = 4'd5;
  localparam logic [3:0] PhPPLen   = 4'd6;
  localparam logic [3:0] PhPSecret = 4'd7;
  localparam logic [3:0] PhDone    = 4'd8;
  localparam logic [3:0] PhClosed  = 4'd9;

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SExec = 2'd1;
  localparam logic [1:0] SFin  = 2'd2;
  localparam logic [1:0] SDec  = 2'd3;

  localparam logic [1:0] OcNoAuth  = 2'd0;
  localparam logic [1:0] OcWait    = 2'd1;
  localparam logic [1:0] OcAccept  = 2'd2;
  localparam logic [1:0] OcReject  = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLR,
    OP_START,
    OP_BYTE,
    OP_END
  } cell_op_e;

  typedef struct packed {
    cell_op_e    op;
    logic        sec;
    logic [7:0]  pos;
    logic [7:0]  data;
    logic        rd_en;
    logic [7:0]  rd_pos;
    logic        txt_we;
    logic        len_we;
    logic [3:0]  ld_entry;
    logic        ld_sec;
    logic [7:0]  ld_pos;
    logic [7:0]  ld_data;
  } cell_ctl_t;

endpackage

// ===== design/s5a_cell.sv =====
// ----------------------------------------------------------------------------
// s5a_cell: one credential entry
// Holds the name and secret text and lengths of one entry, compares received
// bytes against them and passes the any-match flag on to the next cell.
// ----------------------------------------------------------------------------
module s5a_cell #(
  parameter int unsigned MAX_TEXT = s5a_pkg::MaxTextDef,
  parameter int unsigned IDX      = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  s5a_pkg::cell_ctl_t ctl_i,
  input  logic [4:0]         active_i,
  input  logic               any_i,
  output logic               any_o
);

  localparam int unsigned AW = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int unsigned LW = $clog2(MAX_TEXT + 1);

  logic [7:0]    umem [MAX_TEXT];
  logic [7:0]    smem [MAX_TEXT];
  logic [LW-1:0] ulen_q, slen_q;
  logic [7:0]    urd_q, srd_q;
  logic          match_q, match_d, run_q, run_d;
  logic          hit;
  logic [7:0]    txt, slen8;
  logic          below, run_pos, zero_ok;
  logic [LW-1:0] ld_len;

  assign hit    = ({28'd0, ctl_i.ld_entry} == 32'(IDX));
  assign ld_len = (ctl_i.ld_data > 8'(MAX_TEXT)) ? LW'(MAX_TEXT) : LW'(ctl_i.ld_data);

  always_ff @(posedge clk_i) begin
    if (ctl_i.txt_we && hit && !ctl_i.ld_sec) umem[ctl_i.ld_pos[AW-1:0]] <= ctl_i.ld_data;
    if (ctl_i.txt_we && hit &&  ctl_i.ld_sec) smem[ctl_i.ld_pos[AW-1:0]] <= ctl_i.ld_data;
    if (ctl_i.len_we && hit && !ctl_i.ld_sec) ulen_q <= ld_len;
    if (ctl_i.len_we && hit &&  ctl_i.ld_sec) slen_q <= ld_len;
    if (ctl_i.rd_en) begin
      urd_q <= umem[ctl_i.rd_pos[AW-1:0]];
      srd_q <= smem[ctl_i.rd_pos[AW-1:0]];
    end
  end

  assign txt     = ctl_i.sec ? srd_q : urd_q;
  assign slen8   = ctl_i.sec ? 8'(slen_q) : 8'(ulen_q);
  assign below   = ctl_i.pos < slen8;
  assign run_pos = run_q && below && (txt != 8'd0);
  assign zero_ok = run_q && ((ctl_i.pos == slen8) || (below && (txt == 8'd0)));

  always_comb begin
    match_d = match_q;
    run_d   = run_q;
    unique case (ctl_i.op)
      s5a_pkg::OP_CLR:   match_d = 1'b1;
      s5a_pkg::OP_START: run_d = 1'b1;
      s5a_pkg::OP_BYTE: begin
        if (ctl_i.data == 8'd0) begin
          if (!zero_ok) match_d = 1'b0;
        end else begin
          if (!(run_pos && (txt == ctl_i.data))) match_d = 1'b0;
        end
        run_d = run_pos;
      end
      s5a_pkg::OP_END: begin
        if (!zero_ok) match_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b1;
      run_q   <= 1'b0;
    end else begin
      match_q <= match_d;
      run_q   <= run_d;
    end
  end

  assign any_o = any_i | (match_q && (32'(IDX) < {27'd0, active_i}));

endmodule

// ===== design/socks5_auth_handshake_engine_top.sv =====
// ----------------------------------------------------------------------------
// socks5_auth_handshake_engine_top: SOCKS5 method and password negotiation
// An accepted input beat is registered, then the exec state registers the result
// beat; closing a field on a stored byte adds the finish state, and the password
// decision adds the decision state (read the next stored byte per cell, then
// reduce the match chain for the decision).
// A new input beat is taken only in the idle state, not while the last one is in
// work; a pending result beat holds the next client byte. Reset clears the parse
// state, configuration and control registers and sets all matches; the credential
// table is kept.
module socks5_auth_handshake_engine_top #(
  parameter int unsigned MAX_ENTRIES = s5a_pkg::MaxEntriesDef,
  parameter int unsigned MAX_TEXT    = s5a_pkg::MaxTextDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_byte, entry_index, char_position, pad
  input  logic [2:0]  s_axis_tuser,   // cmd, is_secret
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // send_reply, reply_version, reply_code,
                                      // outcome, method_mask, pad
);

  logic       auth_q;
  logic [4:0] cnt_q;
  logic [1:0] state_q, state_d;
  logic [3:0] phase_q, phase_d;
  logic [7:0] fc_q, fc_d, ocnt_q, ocnt_d, nlen_q, nlen_d, slen_q, slen_d;
  logic       none_q, none_d, pw_q, pw_d, nend_q, nend_d, send_q, send_d;
  logic [7:0] byte_q, fin_q, fin_d;
  logic       fsec_q, fsec_d;
  logic       ov_q, ov_d;
  logic [21:0] od_q, od_d;
  logic        accept, can_emit;
  logic [1:0]  cmd;
  logic [7:0]  data_byte, char_pos8;
  s5a_pkg::cell_ctl_t ctl;
  logic [4:0]  active;
  logic        any_w [MAX_ENTRIES+1];

  assign cmd       = s_axis_tuser[1:0];
  assign data_byte = s_axis_tdata[7:0];
  assign char_pos8 = {2'b00, s_axis_tdata[17:12]};
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == s5a_pkg::SIdle);
  assign can_emit  = !ov_q || m_axis_tready;
  assign active    = ({27'd0, cnt_q} > 32'(MAX_ENTRIES)) ? 5'(MAX_ENTRIES) : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auth_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == s5a_pkg::RegEntryCnt) cnt_q <= cfg_data_i;
      else auth_q <= cfg_data_i[0];
    end
  end

  always_comb begin
    logic [7:0] fc_inc;
    logic       none_n, pw_n, dec_m, ended_n, ok;
    logic [7:0] sel;
    state_d = state_q;  phase_d = phase_q; fc_d = fc_q; ocnt_d = ocnt_q;
    nlen_d = nlen_q; slen_d = slen_q; none_d = none_q; pw_d = pw_q;
    nend_d = nend_q; send_d = send_q; fin_d = fin_q; fsec_d = fsec_q;
    ov_d = ov_q && !m_axis_tready;
    od_d = od_q;
    ctl = '0;
    ctl.op = s5a_pkg::OP_NOP;
    ctl.ld_entry = s_axis_tdata[11:8];
    ctl.ld_sec   = s_axis_tuser[2];
    ctl.ld_pos   = char_pos8;
    ctl.ld_data  = data_byte;
    ctl.data     = byte_q;
    ctl.pos      = fc_q;
    fc_inc  = fc_q + 8'd1;
    none_n  = none_q;
    pw_n    = pw_q;
    dec_m   = 1'b0;
    ended_n = 1'b0;
    ok      = 1'b0;
    sel     = s5a_pkg::MethRej;
    unique case (state_q)
      s5a_pkg::SIdle: begin
        if (accept) begin
          unique case (cmd)
            s5a_pkg::CmdText: ctl.txt_we = ({24'd0, char_pos8} < 32'(MAX_TEXT));
            s5a_pkg::CmdLen:  ctl.len_we = 1'b1;
            s5a_pkg::CmdNewCon: begin
              ctl.op = s5a_pkg::OP_CLR;
              phase_d = s5a_pkg::PhMVer; fc_d = '0; ocnt_d = '0; none_d = 1'b0;
              pw_d = 1'b0; nlen_d = '0; slen_d = '0; nend_d = 1'b0; send_d = 1'b0;
            end
            default: begin
              ctl.rd_en = 1'b1;
              ctl.rd_pos = fc_q;
              state_d = s5a_pkg::SExec;
            end
          endcase
        end
      end
      s5a_pkg::SExec: begin
        if (can_emit) begin
          state_d = s5a_pkg::SIdle;
          unique case (phase_q)
            s5a_pkg::PhMVer, s5a_pkg::PhPVer: begin
              if (byte_q != ((phase_q == s5a_pkg::PhMVer) ? s5a_pkg::VerMethod
                                                           : s5a_pkg::VerPasswd)) begin
                ov_d = 1'b1;
                od_d = {s5a_pkg::MaskOff, s5a_pkg::OcReject, 8'd0, 8'd0, 1'b0};
                phase_d = s5a_pkg::PhClosed;
              end else begin
                phase_d = (phase_q == s5a_pkg::PhMVer) ? s5a_pkg::PhMCount
                                                        : s5a_pkg::PhPULen;
              end
            end
            s5a_pkg::PhMCount: begin
              ocnt_d = byte_q; none_n = 1'b0; pw_n = 1'b0; fc_d = '0;
              if (byte_q == 8'd0) dec_m = 1'b1;
              else phase_d = s5a_pkg::PhMList;
            end
            s5a_pkg::PhMList: begin
              none_n = none_q | (byte_q == s5a_pkg::MethNone);
              pw_n   = pw_q | (byte_q == s5a_pkg::MethPass);
              fc_d   = fc_inc;
              dec_m  = (fc_inc >= ocnt_q);
            end
            s5a_pkg::PhPULen, s5a_pkg::PhPPLen: begin
              ctl.op  = s5a_pkg::OP_START;
              fc_d    = '0;
              if (phase_q == s5a_pkg::PhPULen) begin
                nlen_d = byte_q; nend_d = 1'b0;
                phase_d = (byte_q == 8'd0) ? s5a_pkg::PhPPLen : s5a_pkg::PhPName;
              end else begin
                slen_d = byte_q; send_d = 1'b0;
                phase_d = s5a_pkg::PhPSecret;
              end
              if (byte_q == 8'd0) begin
                fin_d = 8'd0;
                fsec_d = (phase_q == s5a_pkg::PhPPLen);
                ctl.rd_en = 1'b1; ctl.rd_pos = 8'd0;
                state_d = s5a_pkg::SFin;
              end
            end
            s5a_pkg::PhPName, s5a_pkg::PhPSecret: begin
              ctl.sec = (phase_q == s5a_pkg::PhPSecret);
              ended_n = ctl.sec ? send_q : nend_q;
              if (!ended_n) begin
                ctl.op = s5a_pkg::OP_BYTE;
                ended_n = (byte_q == 8'd0);
              end
              if (ctl.sec) send_d = ended_n;
              else nend_d = ended_n;
              fc_d = fc_inc;
              if (fc_inc >= (ctl.sec ? slen_q : nlen_q)) begin
                if (!ctl.sec) phase_d = s5a_pkg::PhPPLen;
                fsec_d = ctl.sec;
                fin_d = ctl.sec ? slen_q : nlen_q;
                if (!ended_n) begin
                  ctl.rd_en = 1'b1; ctl.rd_pos = fin_d;
                  state_d = s5a_pkg::SFin;
                end else if (ctl.sec) begin
                  state_d = s5a_pkg::SDec;
                end
              end
            end
            default: ;
          endcase
          none_d = none_n;
          pw_d   = pw_n;
          if (dec_m) begin
            if (auth_q) begin
              if (pw_n) sel = s5a_pkg::MethPass;
            end else if (none_n) begin
              sel = s5a_pkg::MethNone;
            end
            ov_d = 1'b1;
            if (sel == s5a_pkg::MethRej) begin
              od_d = {s5a_pkg::MaskOff, s5a_pkg::OcReject, sel, s5a_pkg::VerMethod, 1'b1};
              phase_d = s5a_pkg::PhClosed;
            end else if (sel == s5a_pkg::MethNone) begin
              od_d = {s5a_pkg::MaskNone, s5a_pkg::OcNoAuth, sel, s5a_pkg::VerMethod, 1'b1};
              phase_d = s5a_pkg::PhDone;
            end else begin
              od_d = {s5a_pkg::MaskPass, s5a_pkg::OcWait, sel, s5a_pkg::VerMethod, 1'b1};
              ctl.op = s5a_pkg::OP_CLR;
              phase_d = s5a_pkg::PhPVer;
            end
          end
        end
      end
      s5a_pkg::SFin: begin
        ctl.op  = s5a_pkg::OP_END;
        ctl.sec = fsec_q;
        ctl.pos = fin_q;
        state_d = fsec_q ? s5a_pkg::SDec : s5a_pkg::SIdle;
      end
      s5a_pkg::SDec: begin
        if (can_emit) begin
          ok = !auth_q || any_w[MAX_ENTRIES];
          ov_d = 1'b1;
          od_d = {s5a_pkg::MaskOff, ok ? s5a_pkg::OcAccept : s5a_pkg::OcReject,
                  ok ? 8'd0 : 8'd1, s5a_pkg::VerPasswd, 1'b1};
          phase_d = ok ? s5a_pkg::PhDone : s5a_pkg::PhClosed;
          state_d = s5a_pkg::SIdle;
        end
      end
      default: state_d = s5a_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= s5a_pkg::SIdle;
      phase_q <= s5a_pkg::PhMVer;
      fc_q <= '0; ocnt_q <= '0; nlen_q <= '0; slen_q <= '0;
      none_q <= 1'b0; pw_q <= 1'b0; nend_q <= 1'b0; send_q <= 1'b0;
      fsec_q <= 1'b0; fin_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fc_q <= fc_d; ocnt_q <= ocnt_d; nlen_q <= nlen_d; slen_q <= slen_d;
      none_q <= none_d; pw_q <= pw_d; nend_q <= nend_d; send_q <= send_d;
      fsec_q <= fsec_d; fin_q <= fin_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    if (accept) byte_q <= data_byte;
  end

  assign any_w[0] = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    s5a_cell #(
      .MAX_TEXT (MAX_TEXT),
      .IDX      (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .active_i (active),
      .any_i    (any_w[g]),
      .any_o    (any_w[g+1])
    );
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {2'd0, od_q};

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != s5a_pkg::SIdle) |-> !s_axis_tready)
    else $error("input taken while busy");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == s5a_pkg::SExec ||
                              $past(state_q) == s5a_pkg::SDec))
    else $error("result raised outside exec or decision");

  a_newcon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == s5a_pkg::CmdNewCon) |=> (phase_q == s5a_pkg::PhMVer))
    else $error("new connection did not restart parse");

  a_fin_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == s5a_pkg::SDec) |-> ($past(state_q) == s5a_pkg::SExec ||
                                    $past(state_q) == s5a_pkg::SFin ||
                                    $past(state_q) == s5a_pkg::SDec))
    else $error("decision entered from idle");

endmodule
